>>> design/rfsh_pkg.sv
// ----------------------------------------------------------------------------
// rfsh_pkg
// Shared field widths and operation codes for the seekable byte ring buffer.
// ----------------------------------------------------------------------------
package rfsh_pkg;

    // Port field widths
    localparam int KIND_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int TGT_W   = 32;
    localparam int SPOS_W  = 32;
    localparam int AVAIL_W = 13;
    localparam int CAP_W   = 13;

    typedef logic [KIND_W-1:0] kind_t;

    // Operation codes carried by the kind field
    localparam kind_t KIND_WRITE = 3'd0;
    localparam kind_t KIND_READ  = 3'd1;
    localparam kind_t KIND_PEEK  = 3'd2;
    localparam kind_t KIND_SEEK  = 3'd3;
    localparam kind_t KIND_CLEAR = 3'd4;

endpackage

>>> design/rfsh_ram.sv
// ----------------------------------------------------------------------------
// rfsh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rfsh_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/ring_fifo_with_seek_history.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_seek_history
// Byte ring buffer with an absolute read position and seek-back history.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) carries one byte operation per transaction:
//   write, read, peek at an absolute position, seek, or clear. The result
//   channel (m_valid/m_ready) returns exactly one transaction per operation:
//   the byte (reads and peeks), an ok flag, the read position and the number
//   of unread bytes after the operation.
//   Each operation walks through the sequencer steps in order (accept,
//   offset, range check, memory access, result); the read data of the byte
//   store is registered. A new operation is accepted only once the previous
//   one has left its result step.
//   A finished result sits in the output register; the next operation is
//   accepted meanwhile and stalls only in its result step while the receiver
//   holds m_ready low.
//   Reset (aresetn low, synchronous) empties the buffer, zeroes the read
//   position and sets the capacity to its default. A write on cfg_wr_en sets
//   the capacity and empties the buffer as well; issue it only while idle.
//   The byte store itself is not cleared; no operation can reach an entry
//   that was never written.
// ----------------------------------------------------------------------------
module ring_fifo_with_seek_history #(
    parameter int DEPTH    = 4096,
    parameter int POS_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [rfsh_pkg::CAP_W-1:0]    cfg_wr_data,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rfsh_pkg::KIND_W-1:0]   s_kind,
    input  logic [rfsh_pkg::BYTE_W-1:0]   s_data_in,
    input  logic [rfsh_pkg::TGT_W-1:0]    s_target_position,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rfsh_pkg::BYTE_W-1:0]   m_data_out,
    output logic                          m_ok,
    output logic [rfsh_pkg::SPOS_W-1:0]   m_stream_position,
    output logic [rfsh_pkg::AVAIL_W-1:0]  m_available
);

    import rfsh_pkg::*;

    // Index into the store, counts up to DEPTH, and a sum width with headroom
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 2;
    localparam int CMP_W   = (POS_BITS > SUM_W) ? POS_BITS : SUM_W;
    localparam int CLAMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int RST_CAP = (DEPTH < 4096) ? DEPTH : 4096;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIFF   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_ACCESS = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]          state_reg, state_next;

    // Captured operation
    kind_t               kind_reg, kind_next;
    logic [BYTE_W-1:0]   data_reg, data_next;
    logic [POS_BITS-1:0] target_reg, target_next;

    // Per-operation scratch
    logic [POS_BITS-1:0] off_reg, off_next;
    logic [POS_BITS-1:0] d_reg, d_next;
    logic                peek_ok_reg, peek_ok_next;
    logic                seek_ok_reg, seek_ok_next;
    logic [IDX_W-1:0]    base_reg, base_next;
    logic                ok_reg, ok_next;

    // Buffer state
    logic [CNT_W-1:0]    capacity_reg, capacity_next;
    logic [IDX_W-1:0]    read_index_reg, read_index_next;
    logic [IDX_W-1:0]    write_index_reg, write_index_next;
    logic [CNT_W-1:0]    unread_reg, unread_next;
    logic [CNT_W-1:0]    hist_reg, hist_next;
    logic [POS_BITS-1:0] read_pos_reg, read_pos_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_data_out_reg, m_data_out_next;
    logic                m_ok_reg, m_ok_next;
    logic [SPOS_W-1:0]   m_spos_reg, m_spos_next;
    logic [AVAIL_W-1:0]  m_avail_reg, m_avail_next;

    // Byte store ports
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [BYTE_W-1:0]   ram_rd_data;

    // Ring arithmetic helpers
    logic [SUM_W-1:0]    cap_ext;
    logic [SUM_W-1:0]    ri_inc_sum, wi_inc_sum;
    logic [IDX_W-1:0]    ri_inc, wi_inc;
    logic [SUM_W-1:0]    peek_sum, base_sum, seek_sum;
    logic [IDX_W-1:0]    peek_idx, seek_idx, base_idx;
    logic [SUM_W-1:0]    held_sum, unread_inc, fill_sum;
    logic [POS_BITS-1:0] d_calc;
    logic [CLAMP_W-1:0]  cfg_ext;
    logic [CNT_W-1:0]    cfg_cap;

    always_comb begin
        cap_ext    = SUM_W'(capacity_reg);

        // advance an index by one around the ring
        ri_inc_sum = SUM_W'(read_index_reg) + SUM_W'(1);
        ri_inc     = (ri_inc_sum >= cap_ext) ? '0 : IDX_W'(ri_inc_sum);
        wi_inc_sum = SUM_W'(write_index_reg) + SUM_W'(1);
        wi_inc     = (wi_inc_sum >= cap_ext) ? '0 : IDX_W'(wi_inc_sum);

        // peek address: offset is below the unread count, so one wrap at most
        peek_sum   = SUM_W'(read_index_reg) + SUM_W'(CNT_W'(off_reg));
        peek_idx   = (peek_sum >= cap_ext) ? IDX_W'(peek_sum - cap_ext) : IDX_W'(peek_sum);

        // oldest retained byte, as a ring index
        base_sum   = SUM_W'(read_index_reg) + cap_ext - SUM_W'(hist_reg);
        base_idx   = (base_sum >= cap_ext) ? IDX_W'(base_sum - cap_ext) : IDX_W'(base_sum);

        // seek target index: distance never exceeds the retained bytes
        seek_sum   = SUM_W'(base_reg) + SUM_W'(CNT_W'(d_reg));
        seek_idx   = (seek_sum >= cap_ext) ? IDX_W'(seek_sum - cap_ext) : IDX_W'(seek_sum);

        held_sum   = SUM_W'(hist_reg) + SUM_W'(unread_reg);
        unread_inc = SUM_W'(unread_reg) + SUM_W'(1);
        fill_sum   = unread_inc + SUM_W'(hist_reg);

        d_calc     = off_reg + POS_BITS'(hist_reg);

        // clamp the written capacity to 1..DEPTH
        cfg_ext    = CLAMP_W'(cfg_wr_data);
        if (cfg_ext == '0) begin
            cfg_cap = CNT_W'(1);
        end else if (cfg_ext > CLAMP_W'(DEPTH)) begin
            cfg_cap = CNT_W'(DEPTH);
        end else begin
            cfg_cap = CNT_W'(cfg_ext);
        end
    end

    always_comb begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        data_next        = data_reg;
        target_next      = target_reg;
        off_next         = off_reg;
        d_next           = d_reg;
        peek_ok_next     = peek_ok_reg;
        seek_ok_next     = seek_ok_reg;
        base_next        = base_reg;
        ok_next          = ok_reg;
        capacity_next    = capacity_reg;
        read_index_next  = read_index_reg;
        write_index_next = write_index_reg;
        unread_next      = unread_reg;
        hist_next        = hist_reg;
        read_pos_next    = read_pos_reg;
        m_valid_next     = m_valid_reg;
        m_data_out_next  = m_data_out_reg;
        m_ok_next        = m_ok_reg;
        m_spos_next      = m_spos_reg;
        m_avail_next     = m_avail_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = write_index_reg;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = read_index_reg;

        // drop the output transaction once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next   = s_kind;
                    data_next   = s_data_in;
                    target_next = POS_BITS'(s_target_position);
                    state_next  = S_DIFF;
                end
            end
            S_DIFF: begin
                // distance from the read point to the target
                off_next   = target_reg - read_pos_reg;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                // seek distance is measured from the oldest retained byte
                d_next       = d_calc;
                peek_ok_next = CMP_W'(off_reg) < CMP_W'(unread_reg);
                seek_ok_next = CMP_W'(d_calc) <= CMP_W'(held_sum);
                base_next    = base_idx;
                state_next   = S_ACCESS;
            end
            S_ACCESS: begin
                ok_next    = 1'b0;
                state_next = S_RESULT;
                case (kind_reg)
                    KIND_WRITE: begin
                        ram_wr_en        = 1'b1;
                        write_index_next = wi_inc;
                        ok_next          = 1'b1;
                        if (unread_reg >= capacity_reg) begin
                            // full of unread data: overwrite the oldest byte
                            read_index_next = ri_inc;
                            read_pos_next   = read_pos_reg + POS_BITS'(1);
                            hist_next       = '0;
                        end else begin
                            unread_next = CNT_W'(unread_inc);
                            if (fill_sum > cap_ext) begin
                                hist_next = CNT_W'(cap_ext - unread_inc);
                            end
                        end
                    end
                    KIND_READ: begin
                        if (unread_reg != '0) begin
                            ram_rd_en       = 1'b1;
                            ram_rd_addr     = read_index_reg;
                            read_index_next = ri_inc;
                            unread_next     = unread_reg - CNT_W'(1);
                            hist_next       = hist_reg + CNT_W'(1);
                            read_pos_next   = read_pos_reg + POS_BITS'(1);
                            ok_next         = 1'b1;
                        end
                    end
                    KIND_PEEK: begin
                        if (peek_ok_reg) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = peek_idx;
                            ok_next     = 1'b1;
                        end
                    end
                    KIND_SEEK: begin
                        if (seek_ok_reg) begin
                            read_index_next = seek_idx;
                            hist_next       = CNT_W'(d_reg);
                            unread_next     = CNT_W'(held_sum - SUM_W'(CNT_W'(d_reg)));
                            read_pos_next   = target_reg;
                            ok_next         = 1'b1;
                        end
                    end
                    KIND_CLEAR: begin
                        read_index_next  = '0;
                        write_index_next = '0;
                        unread_next      = '0;
                        hist_next        = '0;
                        read_pos_next    = '0;
                        ok_next          = 1'b1;
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            S_RESULT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = ok_reg;
                    if (ok_reg && (kind_reg == KIND_READ || kind_reg == KIND_PEEK)) begin
                        m_data_out_next = ram_rd_data;
                    end else begin
                        m_data_out_next = '0;
                    end
                    m_spos_next  = SPOS_W'(read_pos_reg);
                    m_avail_next = AVAIL_W'(unread_reg);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // capacity write empties the buffer
        if (cfg_wr_en) begin
            capacity_next    = cfg_cap;
            read_index_next  = '0;
            write_index_next = '0;
            unread_next      = '0;
            hist_next        = '0;
            read_pos_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            capacity_reg    <= CNT_W'(RST_CAP);
            read_index_reg  <= '0;
            write_index_reg <= '0;
            unread_reg      <= '0;
            hist_reg        <= '0;
            read_pos_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            capacity_reg    <= capacity_next;
            read_index_reg  <= read_index_next;
            write_index_reg <= write_index_next;
            unread_reg      <= unread_next;
            hist_reg        <= hist_next;
            read_pos_reg    <= read_pos_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload and scratch registers need no reset
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        data_reg       <= data_next;
        target_reg     <= target_next;
        off_reg        <= off_next;
        d_reg          <= d_next;
        peek_ok_reg    <= peek_ok_next;
        seek_ok_reg    <= seek_ok_next;
        base_reg       <= base_next;
        ok_reg         <= ok_next;
        m_data_out_reg <= m_data_out_next;
        m_ok_reg       <= m_ok_next;
        m_spos_reg     <= m_spos_next;
        m_avail_reg    <= m_avail_next;
    end

    rfsh_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (data_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_data_out        = m_data_out_reg;
    assign m_ok              = m_ok_reg;
    assign m_stream_position = m_spos_reg;
    assign m_available       = m_avail_reg;

    // Retained bytes never exceed the capacity in use
    a_held_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (SUM_W'(unread_reg) + SUM_W'(hist_reg)) <= SUM_W'(capacity_reg))
        else $error("unread plus history exceeds capacity");

    // Ring indexes stay inside the active part of the store
    a_idx_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W'(read_index_reg) < capacity_reg) && (CNT_W'(write_index_reg) < capacity_reg))
        else $error("ring index outside capacity");

    // A result is only presented out of the result step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result register loaded outside result step");

    // A successful read moves the read position by exactly one
    a_read_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACCESS && kind_reg == KIND_READ && unread_reg != '0 && !cfg_wr_en)
        |=> (read_pos_reg == $past(read_pos_reg) + POS_BITS'(1)))
        else $error("read did not advance the position");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the seekable byte ring buffer. A scoreboard class
// mirrors the buffer state (ring indexes, unread and history counts, read
// position) and predicts every result transaction. Stimulus starts with a
// directed pass over the corner cases at a tiny capacity. A random pass
// follows over several capacity settings. Both channels idle at random, with
// one stretch without idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import rfsh_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 8;
    localparam int DRAIN_CYC   = 12;      // extra idle time after the last result
    localparam int HOLD_CYC    = 400;     // long receiver hold-off
    localparam int ITEMS_PHASE = 140;
    localparam int CYCLE_LIMIT = 600000;
    localparam int STORE_DEPTH = 4096;
    localparam int MAX_REPORTS = 10;

    // Result transaction as seen on the m_ side
    typedef struct packed {
        logic [BYTE_W-1:0]  data_out;
        logic               ok;
        logic [SPOS_W-1:0]  position;
        logic [AVAIL_W-1:0] available;
    } result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: buffer mirror plus queue of pending results
    // ------------------------------------------------------------------------
    class ring_scoreboard;
        bit [BYTE_W-1:0] store [STORE_DEPTH];
        int unsigned     cap;
        int unsigned     rd_idx;
        int unsigned     wr_idx;
        int unsigned     unread;
        int unsigned     hist;
        bit [SPOS_W-1:0] rpos;
        result_t         pending_q[$];
        int              mismatches;
        int              n_ops;
        int              n_rejected;
        int              n_overwrite;
        int              n_hist_drop;
        int              n_seek_ok;

        function new();
            cap = STORE_DEPTH;
            empty_ring();
            mismatches = 0;
            n_ops = 0;
            n_rejected = 0;
            n_overwrite = 0;
            n_hist_drop = 0;
            n_seek_ok = 0;
        endfunction

        function void empty_ring();
            rd_idx = 0;
            wr_idx = 0;
            unread = 0;
            hist = 0;
            rpos = '0;
        endfunction

        // Clamp the register value and empty the buffer
        function void set_capacity(bit [CAP_W-1:0] v);
            if (v == 0)
                cap = 1;
            else if (v > STORE_DEPTH)
                cap = STORE_DEPTH;
            else
                cap = v;
            empty_ring();
        endfunction

        // Apply one accepted operation and queue the result it causes
        function void note_input(kind_t k, bit [BYTE_W-1:0] d, bit [TGT_W-1:0] t);
            result_t         r;
            bit [SPOS_W-1:0] off;
            bit [SPOS_W-1:0] oldest;
            bit [SPOS_W-1:0] seek_dist;
            int unsigned     held;
            int unsigned     base;
            r = '0;
            n_ops++;
            case (k)
                KIND_WRITE: begin
                    store[wr_idx] = d;
                    wr_idx = (wr_idx + 1) % cap;
                    if (unread >= cap) begin
                        rd_idx = (rd_idx + 1) % cap;
                        rpos = rpos + 1;
                        hist = 0;
                        n_overwrite++;
                    end else begin
                        unread++;
                        if (unread + hist > cap) begin
                            hist = cap - unread;
                            n_hist_drop++;
                        end
                    end
                    r.ok = 1'b1;
                end
                KIND_READ: begin
                    if (unread != 0) begin
                        r.data_out = store[rd_idx];
                        rd_idx = (rd_idx + 1) % cap;
                        unread--;
                        hist++;
                        rpos = rpos + 1;
                        r.ok = 1'b1;
                    end
                end
                KIND_PEEK: begin
                    off = t - rpos;
                    if (off < unread) begin
                        r.data_out = store[(rd_idx + off) % cap];
                        r.ok = 1'b1;
                    end
                end
                KIND_SEEK: begin
                    oldest = rpos - hist;
                    seek_dist = t - oldest;
                    held = hist + unread;
                    if (seek_dist <= held) begin
                        base = (rd_idx + cap - hist) % cap;
                        rd_idx = (base + seek_dist) % cap;
                        hist = seek_dist;
                        unread = held - seek_dist;
                        rpos = t;
                        r.ok = 1'b1;
                        n_seek_ok++;
                    end
                end
                KIND_CLEAR: begin
                    empty_ring();
                    r.ok = 1'b1;
                end
                default: ;
            endcase
            if (!r.ok)
                n_rejected++;
            r.position = rpos;
            r.available = unread[AVAIL_W-1:0];
            pending_q.push_back(r);
        endfunction

        // Compare one result transaction with the oldest pending one
        function void check_result(result_t a);
            result_t e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result with nothing pending: data %h ok %b pos %h avail %0d",
                             a.data_out, a.ok, a.position, a.available);
                return;
            end
            e = pending_q.pop_front();
            if (a.data_out !== e.data_out || a.ok !== e.ok ||
                a.position !== e.position || a.available !== e.available) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: result differs: data %h/%h ok %b/%b pos %h/%h ",
                              "avail %0d/%0d (expected/actual)"},
                             e.data_out, a.data_out, e.ok, a.ok,
                             e.position, a.position, e.available, a.available);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals; every block input starts at a known value
    // ------------------------------------------------------------------------
    logic                aclk              = 1'b0;
    logic                aresetn           = 1'b0;
    logic                cfg_wr_en         = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data       = '0;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind            = KIND_WRITE;
    logic [BYTE_W-1:0]   s_data_in         = '0;
    logic [TGT_W-1:0]    s_target_position = '0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic [BYTE_W-1:0]   m_data_out;
    logic                m_ok;
    logic [SPOS_W-1:0]   m_stream_position;
    logic [AVAIL_W-1:0]  m_available;

    ring_scoreboard sb;
    bit             steady    = 1'b0;   // no idling on either side
    bit             hold_req  = 1'b0;   // ask the receiver for its long hold-off
    bit             hold_done = 1'b0;
    int             hold_count = 0;
    int             n_settings = 0;
    int             cycles = 0;

    ring_fifo_with_seek_history dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_data_in         (s_data_in),
        .s_target_position (s_target_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data_out        (m_data_out),
        .m_ok              (m_ok),
        .m_stream_position (m_stream_position),
        .m_available       (m_available)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog: fail the run if it runs far past the slowest correct run
    initial begin
        while (cycles < CYCLE_LIMIT)
            @(posedge aclk) cycles++;
        $display("ring_fifo_with_seek_history: mismatch");
        $finish;
    end

    // Check every result transaction against the mirror
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_data_out, m_ok, m_stream_position, m_available});
    end

    // Receiver: random back-pressure, one long hold-off counted here
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            m_ready <= 1'b0;
            hold_count = hold_count + 1;
            if (hold_count >= HOLD_CYC)
                hold_done = 1'b1;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 24);
        end
    end

    // Offer one transaction, hold it until accepted, then note it.
    // Called right after an edge; lower valid only when a gap follows.
    task automatic push_op(kind_t k, bit [BYTE_W-1:0] d, bit [TGT_W-1:0] t);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 24)
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_kind            <= k;
        s_data_in         <= d;
        s_target_position <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(k, d, t);
    endtask

    // Drop valid and wait until every pending result has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // Write the capacity register; only called while the block is idle
    task automatic write_capacity(bit [CAP_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_capacity(v);
        n_settings++;
    endtask

    // Pick a random operation; peek and seek targets mostly land in range
    task automatic pick_op(output kind_t k, output bit [BYTE_W-1:0] d,
                           output bit [TGT_W-1:0] t);
        int              sel;
        int unsigned     held;
        bit [SPOS_W-1:0] oldest;
        sel    = $urandom_range(0, 99);
        d      = $urandom_range(0, 255);
        t      = $urandom;
        held   = sb.hist + sb.unread;
        oldest = sb.rpos - sb.hist;
        if (sel < 40) begin
            k = KIND_WRITE;
        end else if (sel < 62) begin
            k = KIND_READ;
        end else if (sel < 77) begin
            k = KIND_PEEK;
            if (sb.unread != 0 && $urandom_range(0, 99) < 80) begin
                t = sb.rpos + $urandom_range(0, sb.unread - 1);
            end else begin
                case ($urandom_range(0, 2))
                    0: t = sb.rpos - 1;
                    1: t = sb.rpos + sb.unread;
                    default: ;
                endcase
            end
        end else if (sel < 92) begin
            k = KIND_SEEK;
            if ($urandom_range(0, 99) < 75) begin
                t = oldest + $urandom_range(0, held);
            end else begin
                case ($urandom_range(0, 2))
                    0: t = oldest - 1;
                    1: t = sb.rpos + sb.unread + 1;
                    default: ;
                endcase
            end
        end else if (sel < 95) begin
            k = KIND_CLEAR;
        end else begin
            // undefined codes above clear
            k = kind_t'(KIND_CLEAR + $urandom_range(1, 3));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit [CAP_W-1:0]  caps [10];
        kind_t           k;
        bit [BYTE_W-1:0] d;
        bit [TGT_W-1:0]  t;

        sb = new;
        // includes the extremes: one byte, zero (taken as one), above the store, the store
        caps = '{13'd1, 13'd0, 13'd2, 13'd8191, 13'd5, 13'd3,
                 13'd4096, 13'd16, 13'd33, 13'd4097};

        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed pass at capacity four
        write_capacity(13'd4);
        push_op(KIND_READ,  8'h00, 32'd0);          // read when empty
        push_op(KIND_PEEK,  8'h00, 32'd0);          // peek when empty
        push_op(KIND_SEEK,  8'h00, 32'd0);          // seek to the end of nothing
        push_op(KIND_SEEK,  8'h00, 32'd1);          // seek past the end
        push_op(KIND_WRITE, 8'h00, 32'hFFFF_FFFF);
        push_op(KIND_WRITE, 8'hFF, 32'd0);
        push_op(KIND_WRITE, 8'hA5, 32'd0);
        push_op(KIND_WRITE, 8'h5A, 32'd0);          // now full
        push_op(KIND_WRITE, 8'h3C, 32'd0);          // overwrite the oldest byte
        push_op(KIND_PEEK,  8'h00, 32'd1);          // first unread
        push_op(KIND_PEEK,  8'h00, 32'd4);          // last unread
        push_op(KIND_PEEK,  8'h00, 32'd5);          // one past the end
        push_op(KIND_PEEK,  8'h00, 32'd0);          // behind the read point
        push_op(KIND_READ,  8'h00, 32'd0);
        push_op(KIND_READ,  8'h00, 32'd0);
        push_op(KIND_SEEK,  8'h00, 32'd1);          // back to the oldest history byte
        push_op(KIND_SEEK,  8'h00, 32'd5);          // forward to the end of data
        push_op(KIND_SEEK,  8'h00, 32'd6);          // past the end
        push_op(KIND_SEEK,  8'h00, 32'd0);          // before the history
        push_op(KIND_WRITE, 8'h81, 32'd0);          // drops the oldest history byte
        push_op(kind_t'(KIND_CLEAR + 1), 8'hFF, 32'hFFFF_FFFF);
        push_op(kind_t'(KIND_CLEAR + 2), 8'h00, 32'h0000_0000);
        push_op(kind_t'(KIND_CLEAR + 3), 8'h55, 32'hAAAA_AAAA);
        push_op(KIND_PEEK,  8'h00, 32'hFFFF_FFFF);
        push_op(KIND_CLEAR, 8'h00, 32'd0);
        drain_results();

        // Random pass, one capacity setting per phase
        for (int ph = 0; ph < 10; ph++) begin
            write_capacity(caps[ph]);
            steady   = (ph == 2);               // stretch with no idling at all
            hold_req = hold_req || (ph == 4);   // receiver stalls, input backs up
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                pick_op(k, d, t);
                push_op(k, d, t);
            end
            drain_results();
        end

        $display("covered %0d operations over %0d capacity settings, %0d rejected",
                 sb.n_ops, n_settings, sb.n_rejected);
        $display("%0d overwrites when full, %0d history drops, %0d seeks taken",
                 sb.n_overwrite, sb.n_hist_drop, sb.n_seek_ok);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("ring_fifo_with_seek_history: match");
        else
            $display("ring_fifo_with_seek_history: mismatch");
        $finish;
    end

endmodule

>>> ring_fifo_with_seek_history.f
design/rfsh_pkg.sv
design/rfsh_ram.sv
design/ring_fifo_with_seek_history.sv
tb/testbench.sv
